// ===== src/a64r_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and decode functions for the A64 pc-relative relocator.
// No dependencies.
package a64r_pkg;

  localparam int unsigned MaxEntriesDef = 16;

  localparam logic [1:0] CfgRangeStart = 2'd0;
  localparam logic [1:0] CfgRangeEnd   = 2'd1;
  localparam logic [1:0] CfgBufBase    = 2'd2;
  localparam logic [1:0] CfgProlog     = 2'd3;

  localparam logic [31:0] WLdrX17   = 32'h5800_0051;
  localparam logic [31:0] WBrX17    = 32'hD61F_0220;
  localparam logic [31:0] WBlrX17   = 32'hD63F_0220;
  localparam logic [31:0] WSkip     = 32'h1400_0003;
  localparam logic [31:0] WCondMask = 32'hFF00_001F;
  localparam logic [31:0] WTbMask   = 32'hFFF8_001F;
  localparam logic [31:0] WStp      = 32'hA93F_47F0;
  localparam logic [31:0] WLdp      = 32'hF85F_83F1;
  localparam logic [31:0] WLdrLit   = 32'h5800_0060;
  localparam logic [31:0] WAdrLit   = 32'h5800_0040;
  localparam logic [31:0] WLdrX17B  = 32'h5800_0091;
  localparam logic [31:0] WSimdQ    = 32'h3DC0_0220;
  localparam logic [63:0] PageMask  = 64'hFFFF_FFFF_FFFF_F000;

  typedef enum logic [4:0] {
    K_NONE, K_B, K_BCOND, K_BL, K_ADR, K_ADRP, K_LDR32, K_LDR64, K_LDRSW,
    K_PRFM, K_SIMD32, K_SIMD64, K_SIMD128, K_CBZ, K_CBNZ, K_TBZ, K_TBNZ
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_CHECK, S_DECIDE, S_WALK, S_MOVE, S_EMIT, S_FAIL
  } state_e;

  typedef struct packed {
    logic        op;
    logic [31:0] instruction;
    logic [63:0] pc_value;
    logic [4:0]  length_bytes;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        status;
    logic [4:0]  total_bytes;
  } res_t;

  typedef struct packed {
    logic       accept;
    logic       calc;
    logic       check;
    logic       walk_init;
    logic       walk;
    logic       move;
    logic       emit;
    logic       fail;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       inr;
    logic       move_en;
    logic       fail_en;
    logic       walk_done;
    logic [2:0] nwords;
  } sts_t;

  function automatic kind_e classify(input logic [31:0] w);
    kind_e k;
    k = K_NONE;
    if ((w & 32'hFC00_0000) == 32'h1400_0000) k = K_B;
    else if ((w & 32'hFF00_0010) == 32'h5400_0000) k = K_BCOND;
    else if ((w & 32'hFC00_0000) == 32'h9400_0000) k = K_BL;
    else if ((w & 32'h9F00_0000) == 32'h1000_0000) k = K_ADR;
    else if ((w & 32'h9F00_0000) == 32'h9000_0000) k = K_ADRP;
    else if ((w & 32'hFF00_0000) == 32'h1800_0000) k = K_LDR32;
    else if ((w & 32'hFF00_0000) == 32'h5800_0000) k = K_LDR64;
    else if ((w & 32'hFF00_0000) == 32'h9800_0000) k = K_LDRSW;
    else if ((w & 32'hFF00_0000) == 32'hD800_0000) k = K_PRFM;
    else if ((w & 32'hFF00_0000) == 32'h1C00_0000) k = K_SIMD32;
    else if ((w & 32'hFF00_0000) == 32'h5C00_0000) k = K_SIMD64;
    else if ((w & 32'hFF00_0000) == 32'h9C00_0000) k = K_SIMD128;
    else if ((w & 32'h7F00_0000) == 32'h3400_0000) k = K_CBZ;
    else if ((w & 32'h7F00_0000) == 32'h3500_0000) k = K_CBNZ;
    else if ((w & 32'h7F00_0000) == 32'h3600_0000) k = K_TBZ;
    else if ((w & 32'h7F00_0000) == 32'h3700_0000) k = K_TBNZ;
    return k;
  endfunction

  function automatic logic [2:0] word_count(input kind_e k);
    logic [2:0] n;
    case (k) inside
      K_NONE:                                 n = 3'd1;
      K_ADR, K_ADRP:                          n = 3'd4;
      K_PRFM, K_SIMD32, K_SIMD64, K_SIMD128:  n = 3'd7;
      default:                                n = 3'd5;
    endcase
    return n;
  endfunction

endpackage

// ===== src/a64_pc_relative_relocator.sv =====
`timescale 1ns / 1ps
// Top level of the A64 pc-relative relocator: controller plus datapath.
// Depends on a64r_pkg, a64r_ctrl, a64r_dp.

// A rewrite beat (op 1) is taken when start is high and busy low. Target
// calculation and range check follow in the calc and check states, then the
// decide state. A target in range that is moved into the buffer is first
// found by walking the length table, which has one registered read port,
// and then a move state. One word is then built per cycle, 1 to 7 words,
// each shown on res_o with res_valid_o in the next cycle; results cannot
// be stalled. A failed rewrite gives a single beat from the fail state
// that follows the decide state. Busy drops in the cycle of the last beat.
// An append beat (op 0) leaves busy low.
module a64_pc_relative_relocator import a64r_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  cmd_t cmd;
  sts_t sts;

  a64r_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (item_i.op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  a64r_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTH
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status) |-> res_o.last) else $error("fail beat not last");
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o) else $error("beat after last");
  a_rewrite_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op) |=> busy) else $error("rewrite not started");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !$past(busy)) |-> !res_valid_o) else $error("beat while idle");
`endif

endmodule

// ===== src/a64r_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the relocator: accept, target, range check, table walk, emit or fail.
// Depends on a64r_pkg.
module a64r_ctrl import a64r_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  op_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_q, state_d;
  logic [2:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (start_i && op_i) state_d = S_CALC;
      end
      S_CALC:  state_d = S_CHECK;
      S_CHECK: state_d = S_DECIDE;
      S_DECIDE: begin
        if (sts_i.inr && sts_i.fail_en) state_d = S_FAIL;
        else if (sts_i.inr && sts_i.move_en) state_d = S_WALK;
        else state_d = S_EMIT;
      end
      S_WALK: if (sts_i.walk_done) state_d = S_MOVE;
      S_MOVE:  state_d = S_EMIT;
      S_EMIT: begin
        idx_d = idx_q + 3'd1;
        if (idx_q == sts_i.nwords - 3'd1) state_d = S_IDLE;
      end
      S_FAIL:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.idx    = idx_q;
    unique case (state_q)
      S_IDLE:   cmd_o.accept    = start_i;
      S_CALC:   cmd_o.calc      = 1'b1;
      S_CHECK:  cmd_o.check     = 1'b1;
      S_DECIDE: cmd_o.walk_init = 1'b1;
      S_WALK:   cmd_o.walk      = 1'b1;
      S_MOVE:   cmd_o.move      = 1'b1;
      S_EMIT:   cmd_o.emit      = 1'b1;
      S_FAIL:   cmd_o.fail      = 1'b1;
      default:  cmd_o.accept    = 1'b0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== src/a64r_dp.sv =====
`timescale 1ns / 1ps
// Relocator datapath: config registers, length table, target math, word build.
// Depends on a64r_pkg.
module a64r_dp import a64r_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        res_valid_o,
  output res_t        res_o
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [63:0] rstart_q, rend_q, base_q;
  logic [7:0]  prolog_q;
  logic [4:0]  tbl [MAX_ENTRIES];
  logic [CW-1:0] cnt_q, widx_q;
  logic [31:0] ins_q;
  logic [63:0] pc_q, a_q, cur_q, off_q;
  kind_e       kind_q;
  logic        inr_q, pend_q, valid_q;
  logic [4:0]  rd_q;
  res_t        res_q;
  logic        more;
  logic [63:0] disp;
  logic [4:0]  rt;
  logic [31:0] w;
  logic [2:0]  n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rstart_q <= '0;
      rend_q   <= '0;
      base_q   <= '0;
      prolog_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRangeStart: rstart_q <= cfg_data_i;
        CfgRangeEnd:   rend_q   <= cfg_data_i;
        CfgBufBase:    base_q   <= cfg_data_i;
        CfgProlog:     prolog_q <= cfg_data_i[7:0];
        default:       prolog_q <= prolog_q;
      endcase
    end
  end

  // length table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !item_i.op && cnt_q < CW'(MAX_ENTRIES))
      tbl[cnt_q[IW-1:0]] <= item_i.length_bytes;
    if (cmd_i.walk && more) rd_q <= tbl[widx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && !item_i.op && cnt_q < CW'(MAX_ENTRIES))
        cnt_q <= cnt_q + CW'(1);
      if (cmd_i.walk_init) pend_q <= 1'b0;
      else if (cmd_i.walk) pend_q <= more;
      valid_q <= cmd_i.emit | cmd_i.fail;
    end
  end

  always_comb begin
    disp = '0;
    case (kind_q) inside
      K_B, K_BL:
        disp = {{36{ins_q[25]}}, ins_q[25:0], 2'b00};
      K_TBZ, K_TBNZ:
        disp = {{48{ins_q[18]}}, ins_q[18:5], 2'b00};
      K_ADR:
        disp = {{43{ins_q[23]}}, ins_q[23:5], ins_q[30:29]};
      K_ADRP:
        disp = {{31{ins_q[23]}}, ins_q[23:5], ins_q[30:29], 12'h000};
      default:
        disp = {{43{ins_q[23]}}, ins_q[23:5], 2'b00};
    endcase
  end

  assign more = (widx_q < cnt_q) && (cur_q < a_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ins_q  <= item_i.instruction;
      pc_q   <= item_i.pc_value;
      kind_q <= classify(item_i.instruction);
    end
    if (cmd_i.calc) a_q <= ((kind_q == K_ADRP) ? (pc_q & PageMask) : pc_q) + disp;
    if (cmd_i.check) inr_q <= (rstart_q <= a_q) && (a_q < rend_q);
    if (cmd_i.walk_init) begin
      cur_q  <= rstart_q;
      off_q  <= '0;
      widx_q <= '0;
    end else if (cmd_i.walk) begin
      if (pend_q) off_q <= off_q + 64'(rd_q);
      if (more) begin
        cur_q  <= cur_q + 64'd4;
        widx_q <= widx_q + CW'(1);
      end
    end
    if (cmd_i.move) a_q <= base_q + 64'(prolog_q) + off_q;
  end

  assign rt = ins_q[4:0];
  assign n  = word_count(kind_q);

  always_comb begin
    w = ins_q;
    case (kind_q) inside
      K_B, K_BL: begin
        case (cmd_i.idx)
          3'd0:    w = WLdrX17;
          3'd1:    w = WSkip;
          3'd2:    w = a_q[31:0];
          3'd3:    w = a_q[63:32];
          default: w = (kind_q == K_BL) ? WBlrX17 : WBrX17;
        endcase
      end
      K_BCOND, K_CBZ, K_CBNZ, K_TBZ, K_TBNZ: begin
        case (cmd_i.idx)
          3'd0: begin
            if (kind_q == K_BCOND) w = ((ins_q ^ 32'h1) & WCondMask) | 32'h0A0;
            else if (kind_q == K_TBZ || kind_q == K_TBNZ)
              w = ((ins_q ^ 32'h0100_0000) & WTbMask) | 32'h0A0;
            else w = ((ins_q ^ 32'h0100_0000) & WCondMask) | 32'h0A0;
          end
          3'd1:    w = WLdrX17;
          3'd2:    w = WBrX17;
          3'd3:    w = a_q[31:0];
          default: w = a_q[63:32];
        endcase
      end
      K_ADR, K_ADRP: begin
        case (cmd_i.idx)
          3'd0:    w = WAdrLit | {27'd0, rt};
          3'd1:    w = WSkip;
          3'd2:    w = a_q[31:0];
          default: w = a_q[63:32];
        endcase
      end
      K_LDR32, K_LDR64, K_LDRSW: begin
        case (cmd_i.idx)
          3'd0: w = WLdrLit | {27'd0, rt};
          3'd1: begin
            if (kind_q == K_LDR32) w = 32'hB940_0000;
            else if (kind_q == K_LDR64) w = 32'hF940_0000;
            else w = 32'hB980_0000;
            w = w | {22'd0, rt, rt};
          end
          3'd2:    w = WSkip;
          3'd3:    w = a_q[31:0];
          default: w = a_q[63:32];
        endcase
      end
      K_PRFM, K_SIMD32, K_SIMD64, K_SIMD128: begin
        case (cmd_i.idx)
          3'd0: w = WStp;
          3'd1: w = WLdrX17B;
          3'd2: begin
            if (kind_q == K_PRFM) w = 32'hF980_0220;
            else if (kind_q == K_SIMD32) w = 32'hBD40_0220;
            else if (kind_q == K_SIMD64) w = 32'hFD40_0220;
            else w = WSimdQ;
            w = w | {27'd0, rt};
          end
          3'd3:    w = WLdp;
          3'd4:    w = WSkip;
          3'd5:    w = a_q[31:0];
          default: w = a_q[63:32];
        endcase
      end
      default: w = ins_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fail) begin
      res_q <= '{word: '0, last: 1'b1, status: 1'b1, total_bytes: '0};
    end else if (cmd_i.emit) begin
      res_q.word        <= w;
      res_q.last        <= (cmd_i.idx == n - 3'd1);
      res_q.status      <= 1'b0;
      res_q.total_bytes <= {n, 2'b00};
    end
  end

  assign sts_o.inr       = inr_q;
  assign sts_o.move_en   = (kind_q == K_B) || (kind_q == K_BL) || (kind_q == K_BCOND) ||
                           (kind_q == K_CBZ) || (kind_q == K_CBNZ) || (kind_q == K_TBZ) ||
                           (kind_q == K_TBNZ) || (kind_q == K_PRFM);
  assign sts_o.fail_en   = (kind_q == K_ADR) || (kind_q == K_ADRP) || (kind_q == K_LDR32) ||
                           (kind_q == K_LDR64) || (kind_q == K_LDRSW) ||
                           (kind_q == K_SIMD32) || (kind_q == K_SIMD64) ||
                           (kind_q == K_SIMD128);
  assign sts_o.walk_done = !pend_q && !more;
  assign sts_o.nwords    = n;
  assign res_valid_o     = valid_q;
  assign res_o           = res_q;

endmodule
